// ===== hdl/easc_pkg.sv =====
// ----------------------------------------------------------------------------
// easc_pkg
// Shared types and character constants for the email address syntax checker.
// ----------------------------------------------------------------------------
package easc_pkg;

  // Where the checker stands inside the address.
  typedef enum logic [1:0] {
    PH_USER   = 2'd0,
    PH_AT     = 2'd1,
    PH_DOMAIN = 2'd2
  } phase_t;

  // Class of the previous domain byte.
  typedef enum logic [1:0] {
    CL_OTHER = 2'd0,
    CL_DOT   = 2'd1,
    CL_DASH  = 2'd2
  } prev_class_t;

  // Classification of one byte, passed from the classifier to the checker.
  typedef struct packed {
    logic alnum;
    logic user_ok;
    logic dot;
    logic dash;
    logic at;
  } char_class_t;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOLR  = 8'h24;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUES  = 8'h3F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_TILDE = 8'h7E;

endpackage

// ===== hdl/email_address_syntax_check_unit.sv =====
// Path: a closing item is held in the input stage register until the result
// register is free, then moves into it, where out_valid offers its verdict.
// Throughput: one byte per cycle; a byte is taken while a verdict waits in
// the output register, and only a closing item waits for that register.
// Reset: synchronous, active low; clears both stages and the running state,
// so the next byte starts a new address.
// ----------------------------------------------------------------------------
// email_address_syntax_check_unit
// Streams an email address one byte per transfer and reports whether its
// syntax is valid on the item that closes the address.
// ----------------------------------------------------------------------------
module email_address_syntax_check_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_is_last,
  input  logic       in_address_empty,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_valid
);

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_empty_r;

  // Running state of the current address.
  easc_pkg::phase_t      phase_r,  phase_nxt;
  easc_pkg::prev_class_t prev_r,   prev_nxt;
  logic                  failed_r, failed_nxt;
  logic                  user_ne_r, user_ne_nxt;

  // Result register.
  logic out_valid_r;
  logic out_is_valid_r;

  easc_pkg::char_class_t cls;
  logic closing;
  logic verdict;
  logic slot_free;
  logic advance;

  easc_classify u_classify (
    .char_byte  (s1_char_r),
    .char_class (cls)
  );

  // Handshake between the stages.
  assign closing   = s1_last_r | s1_empty_r;
  assign slot_free = ~out_valid_r | out_ready;
  assign advance   = s1_valid_r & (~closing | slot_free);
  assign in_ready  = ~s1_valid_r | advance;

  // Next state of the address checker for the byte in the input stage.
  always_comb begin
    logic           f;
    easc_pkg::phase_t      ph;
    easc_pkg::prev_class_t pc;
    logic           une;
    f   = failed_r;
    ph  = phase_r;
    pc  = prev_r;
    une = user_ne_r;
    unique case (phase_r)
      easc_pkg::PH_USER: begin
        if (cls.at) begin
          if (!user_ne_r) f = 1'b1;
          ph = easc_pkg::PH_AT;
          pc = easc_pkg::CL_OTHER;
        end else begin
          une = 1'b1;
          if (!cls.user_ok) f = 1'b1;
        end
      end
      easc_pkg::PH_AT: begin
        if (!cls.alnum) f = 1'b1;
        ph = easc_pkg::PH_DOMAIN;
      end
      default: begin
        if (cls.dot) begin
          if (prev_r != easc_pkg::CL_OTHER) f = 1'b1;
        end else if (cls.dash) begin
          if (prev_r == easc_pkg::CL_DOT) f = 1'b1;
        end else if (!cls.alnum) begin
          f = 1'b1;
        end
        ph = easc_pkg::PH_DOMAIN;
      end
    endcase
    // The previous class follows every domain byte.
    if (phase_r != easc_pkg::PH_USER) begin
      pc = cls.dot  ? easc_pkg::CL_DOT :
           cls.dash ? easc_pkg::CL_DASH : easc_pkg::CL_OTHER;
    end

    verdict = ~f & (ph == easc_pkg::PH_DOMAIN) & (pc == easc_pkg::CL_OTHER);

    // A closing item returns the state to the start of a new address.
    if (closing) begin
      phase_nxt   = easc_pkg::PH_USER;
      prev_nxt    = easc_pkg::CL_OTHER;
      failed_nxt  = 1'b0;
      user_ne_nxt = 1'b0;
    end else begin
      phase_nxt   = ph;
      prev_nxt    = pc;
      failed_nxt  = f;
      user_ne_nxt = une;
    end
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char_r  <= in_char_byte;
      s1_last_r  <= in_is_last;
      s1_empty_r <= in_address_empty;
    end
  end

  // Address state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= easc_pkg::PH_USER;
      prev_r    <= easc_pkg::CL_OTHER;
      failed_r  <= 1'b0;
      user_ne_r <= 1'b0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      prev_r    <= prev_nxt;
      failed_r  <= failed_nxt;
      user_ne_r <= user_ne_nxt;
    end
  end

  // Result register; an empty address is always invalid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && closing) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && closing) begin
      out_is_valid_r <= s1_empty_r ? 1'b0 : verdict;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_valid = out_is_valid_r;

endmodule

// ===== hdl/easc_classify.sv =====
// ----------------------------------------------------------------------------
// easc_classify
// Sorts one address byte into the character classes that the checker needs.
// ----------------------------------------------------------------------------
module easc_classify (
  input  logic [7:0]                char_byte,
  output easc_pkg::char_class_t     char_class
);

  logic alnum;
  logic symbol;

  // Letters and digits; bytes above 127 fall outside every range.
  assign alnum = ((char_byte >= 8'h61) && (char_byte <= 8'h7A)) ||
                 ((char_byte >= 8'h41) && (char_byte <= 8'h5A)) ||
                 ((char_byte >= 8'h30) && (char_byte <= 8'h39));

  // Symbols allowed in the user part besides letters and digits.
  always_comb begin
    unique case (char_byte)
      easc_pkg::CH_DOT,   easc_pkg::CH_BANG,  easc_pkg::CH_HASH,
      easc_pkg::CH_DOLR,  easc_pkg::CH_PCT,   easc_pkg::CH_AMP,
      easc_pkg::CH_APOS,  easc_pkg::CH_STAR,  easc_pkg::CH_PLUS,
      easc_pkg::CH_DASH,  easc_pkg::CH_SLASH, easc_pkg::CH_EQ,
      easc_pkg::CH_QUES,  easc_pkg::CH_CARET, easc_pkg::CH_UNDER,
      easc_pkg::CH_BTICK, easc_pkg::CH_LBRC,  easc_pkg::CH_PIPE,
      easc_pkg::CH_RBRC,  easc_pkg::CH_TILDE: symbol = 1'b1;
      default:                                symbol = 1'b0;
    endcase
  end

  assign char_class.alnum   = alnum;
  assign char_class.user_ok = alnum | symbol;
  assign char_class.dot     = (char_byte == easc_pkg::CH_DOT);
  assign char_class.dash    = (char_byte == easc_pkg::CH_DASH);
  assign char_class.at      = (char_byte == easc_pkg::CH_AT);

endmodule

// ===== hdl/easc_checker.sv =====
// ----------------------------------------------------------------------------
// easc_checker
// Port-level assertions for the email address syntax checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module easc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_address_empty,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_valid
);

  // After reset both stages are empty.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("stages not empty after reset");

  // An empty address gives an invalid verdict, through the input stage and then the result register, when not stalled.
  a_empty_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_address_empty) ##1 out_ready
      |=> out_valid && !out_is_valid)
    else $error("empty address did not give an invalid verdict");

  // A stalled verdict stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  // A stalled verdict keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_is_valid))
    else $error("verdict changed while stalled");

endmodule

bind email_address_syntax_check_unit easc_checker u_easc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_address_empty (in_address_empty),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_is_valid     (out_is_valid)
);

// ===== bench/tb_email_address_syntax_check_unit.sv =====
// ----------------------------------------------------------------------------
// tb_email_address_syntax_check_unit
// Self-checking bench for the email address syntax checker. A short directed
// set of addresses comes first, then randomly built addresses (mostly close to
// well formed, some noise and some cut short by an empty item). Both sides
// idle in random bursts. A scoreboard tracks the checker state, predicts every
// verdict and compares each verdict transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_email_address_syntax_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT = 2000;
  localparam int CALM_FROM = 1700;
  localparam int STALL_LIMIT = 2000;
  localparam int NUM_SYMBOLS = 22;

  // Non-alphanumeric bytes that the user part accepts.
  localparam logic [7:0] USER_SYMBOLS [NUM_SYMBOLS] = '{
    easc_pkg::CH_DOT, easc_pkg::CH_DASH, easc_pkg::CH_BANG, easc_pkg::CH_HASH,
    easc_pkg::CH_DOLR, easc_pkg::CH_PCT, easc_pkg::CH_AMP, easc_pkg::CH_APOS,
    easc_pkg::CH_STAR, easc_pkg::CH_PLUS, easc_pkg::CH_SLASH, easc_pkg::CH_EQ,
    easc_pkg::CH_QUES, easc_pkg::CH_CARET, easc_pkg::CH_UNDER, easc_pkg::CH_BTICK,
    easc_pkg::CH_LBRC, easc_pkg::CH_PIPE, easc_pkg::CH_RBRC, easc_pkg::CH_TILDE,
    easc_pkg::CH_DOT, easc_pkg::CH_DASH
  };

  // Tracks the running address state and the verdicts still to come.
  class address_verdict_board;
    easc_pkg::phase_t      ph;
    easc_pkg::prev_class_t prev;
    bit          broken;
    bit          user_seen;
    bit          expected_verdicts[$];
    int          mismatches;
    int          verdicts_checked;
    int          valid_verdicts;

    function new();
      clear();
      mismatches = 0;
      verdicts_checked = 0;
      valid_verdicts = 0;
    endfunction

    function void clear();
      ph = easc_pkg::PH_USER;
      prev = easc_pkg::CL_OTHER;
      broken = 1'b0;
      user_seen = 1'b0;
    endfunction

    function bit alnum(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9");
    endfunction

    // Notes one accepted input transfer and predicts its verdict, if any.
    function void note_byte(logic [7:0] c, logic last, logic empty);
      bit user_ok;
      bit ok;
      user_ok = alnum(c);
      foreach (USER_SYMBOLS[i]) begin
        if (c == USER_SYMBOLS[i]) user_ok = 1'b1;
      end
      // An empty address drops anything streamed so far and is invalid.
      if (empty) begin
        clear();
        expected_verdicts.push_back(1'b0);
        return;
      end
      if (ph == easc_pkg::PH_USER) begin
        // The first '@' ends the user part, which must hold something.
        if (c == easc_pkg::CH_AT) begin
          if (!user_seen) broken = 1'b1;
          ph = easc_pkg::PH_AT;
          prev = easc_pkg::CL_OTHER;
        end else begin
          user_seen = 1'b1;
          if (!user_ok) broken = 1'b1;
        end
      end else begin
        // Domain rules: no leading dot or dash, no dot after dot or dash,
        // no dash after dot, nothing but letters, digits, dots and dashes.
        if (ph == easc_pkg::PH_AT) begin
          if (!alnum(c)) broken = 1'b1;
        end else if (c == easc_pkg::CH_DOT) begin
          if (prev != easc_pkg::CL_OTHER) broken = 1'b1;
        end else if (c == easc_pkg::CH_DASH) begin
          if (prev == easc_pkg::CL_DOT) broken = 1'b1;
        end else if (!alnum(c)) begin
          broken = 1'b1;
        end
        ph = easc_pkg::PH_DOMAIN;
        prev = (c == easc_pkg::CH_DOT)  ? easc_pkg::CL_DOT :
               (c == easc_pkg::CH_DASH) ? easc_pkg::CL_DASH : easc_pkg::CL_OTHER;
      end
      if (last) begin
        ok = !broken && ph == easc_pkg::PH_DOMAIN && prev == easc_pkg::CL_OTHER;
        expected_verdicts.push_back(ok);
        clear();
      end
    endfunction

    // Compares one verdict transfer with the oldest prediction.
    function void check_verdict(logic actual);
      bit want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict with none pending: expected none, actual %0b",
                 $time, actual);
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      verdicts_checked++;
      if (actual !== want) begin
        $display("%0t: is_valid mismatch: expected %0b, actual %0b",
                 $time, want, actual);
        mismatches++;
      end else if (want) begin
        valid_verdicts++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_byte;
  logic       in_is_last;
  logic       in_address_empty;
  logic       out_valid;
  logic       out_ready;
  logic       out_is_valid;

  address_verdict_board verdict_board = new();
  bit calm;
  int items_driven;
  int quiet_cycles;

  email_address_syntax_check_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_is_last       (in_is_last),
    .in_address_empty (in_address_empty),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_valid     (out_is_valid)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) verdict_board.check_verdict(out_is_valid);
    if (rst_n && in_valid && in_ready) begin
      verdict_board.note_byte(in_char_byte, in_is_last, in_address_empty);
    end
  end

  // Give up when neither channel has moved a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, giving up", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: ready with random stall bursts, none near the end.
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Drives one input item and waits for its transfer.
  task automatic send_item(input logic [7:0] c, input logic last, input logic empty);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_is_last <= last;
    in_address_empty <= empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_driven++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
  endtask

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // Builds one address, mostly near well formed, and streams it. A few are
  // cut short by an empty item, which throws the partial address away.
  task automatic send_random_address();
    logic [7:0] addr[$];
    int ulen;
    int dlen;
    int pick;
    int cut;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 6)) addr.push_back(8'($urandom_range(0, 255)));
    end else begin
      ulen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      repeat (ulen) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) addr.push_back(rand_alnum());
        else if (pick < 95) addr.push_back(USER_SYMBOLS[$urandom_range(0, NUM_SYMBOLS - 1)]);
        else addr.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 19) != 0) addr.push_back(easc_pkg::CH_AT);
      dlen = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 8);
      repeat (dlen) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) addr.push_back(easc_pkg::CH_DOT);
        else if (pick < 14) addr.push_back(easc_pkg::CH_DASH);
        else if (pick < 16) addr.push_back(8'($urandom_range(0, 255)));
        else if (pick < 17) addr.push_back(easc_pkg::CH_AT);
        else addr.push_back(rand_alnum());
      end
      if (addr.size() == 0) addr.push_back(rand_alnum());
    end
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, addr.size() - 1) : -1;
    foreach (addr[i]) begin
      if (i == cut) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        return;
      end
      send_item(addr[i], i == addr.size() - 1, 1'b0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_byte = 8'h00;
    in_is_last = 1'b0;
    in_address_empty = 1'b0;
    calm = 1'b0;
    items_driven = 0;
    quiet_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Empty addresses, with and without the last flag.
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    // Minimal valid address, empty user part, missing '@'.
    send_text("a@b");
    send_text("@b");
    send_text("x");
    // User symbol with a dotted domain, then a dot after a dash at the end.
    send_text("~@9.z");
    send_text("q@z-.");
    // Bytes above 127 in both parts.
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(easc_pkg::CH_AT, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    // A partial address dropped by an empty item.
    send_item("k", 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    // Domain that starts with a dash.
    send_text("a@-");

    while (items_driven < ITEM_COUNT) begin
      calm = items_driven >= CALM_FROM;
      send_random_address();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the pending verdicts, then allow for the pipeline depth.
    while (verdict_board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Streamed %0d input items; checked %0d verdicts (%0d valid, %0d invalid).",
             items_driven, verdict_board.verdicts_checked, verdict_board.valid_verdicts,
             verdict_board.verdicts_checked - verdict_board.valid_verdicts);
    $display("Mismatches: %0d, verdicts still pending: %0d.", verdict_board.mismatches,
             verdict_board.expected_verdicts.size());
    if (verdict_board.mismatches == 0 && verdict_board.expected_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== email_address_syntax_check_unit.f =====
hdl/easc_pkg.sv
hdl/easc_classify.sv
hdl/email_address_syntax_check_unit.sv
hdl/easc_checker.sv
bench/tb_email_address_syntax_check_unit.sv
